// ----- sv/waypoint_list_engine_macros.svh -----
// assertion macros for the waypoint list engine, included by wle_dp
`ifndef WAYPOINT_LIST_ENGINE_MACROS_SVH
`define WAYPOINT_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define WLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("waypoint list engine check failed");
`define WLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("waypoint list engine check failed");
`else
`define WLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/wle_pkg.sv -----
package wle_pkg;

	localparam int unsigned DEPTH   = 64;
	localparam int unsigned ADDR_W  = $clog2(DEPTH);
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned COORD_W = 16;

	typedef enum logic [3:0] {
		OP_APPEND    = 4'd0,
		OP_EDIT      = 4'd1,
		OP_INSERT    = 4'd2,
		OP_REMOVE    = 4'd3,
		OP_DROP      = 4'd4,
		OP_CLEAR     = 4'd5,
		OP_READ      = 4'd6,
		OP_READ_LAST = 4'd7,
		OP_PRUNE     = 4'd8
	} op_t;

	typedef struct packed {
		logic [3:0]                kind;
		logic [IDX_W-1:0]          index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic [CNT_W-1:0]          point_count;
		logic                      status;
	} res_t;

	// y in the upper half, x in the lower half
	typedef struct packed {
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} point_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_SIMPLE,
		CMD_RD,
		CMD_BEGIN,
		CMD_SHIFT,
		CMD_PUT,
		CMD_REM_END,
		CMD_PR_READ,
		CMD_FSET,
		CMD_FILL,
		CMD_PR_END
	} cmd_t;

	typedef struct packed {
		logic [3:0] kind;
		logic       reject;
		logic       no_move;
		logic       last;
		logic       fill_done;
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_RD_WAIT,
		S_SHIFT,
		S_DRAIN,
		S_PUT,
		S_PR_READ,
		S_PR_DRAIN,
		S_PR_FSET,
		S_PR_FILL
	} state_t;

endpackage

// ----- sv/wle_ctrl.sv -----
module wle_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  wle_pkg::stat_t stat,
	output logic           busy,
	output wle_pkg::cmd_t  cmd
);
	import wle_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd     = CMD_CAPTURE;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.reject) begin
					cmd     = CMD_SIMPLE;
					state_d = S_IDLE;
				end else begin
					case (stat.kind) inside
						OP_READ, OP_READ_LAST: begin
							cmd     = CMD_RD;
							state_d = S_RD_WAIT;
						end
						OP_INSERT: begin
							if (stat.no_move) begin
								state_d = S_PUT;
							end else begin
								cmd     = CMD_BEGIN;
								state_d = S_SHIFT;
							end
						end
						OP_REMOVE: begin
							if (stat.no_move) begin
								cmd     = CMD_REM_END;
								state_d = S_IDLE;
							end else begin
								cmd     = CMD_BEGIN;
								state_d = S_SHIFT;
							end
						end
						OP_PRUNE: begin
							if (stat.no_move) begin
								cmd     = CMD_SIMPLE;
								state_d = S_IDLE;
							end else begin
								cmd     = CMD_BEGIN;
								state_d = S_PR_READ;
							end
						end
						default: begin
							cmd     = CMD_SIMPLE;
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RD_WAIT: begin
				state_d = S_IDLE;
			end
			S_SHIFT: begin
				cmd = CMD_SHIFT;
				if (stat.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last moved word is written in this cycle
				if (stat.kind == OP_INSERT) begin
					state_d = S_PUT;
				end else begin
					cmd     = CMD_REM_END;
					state_d = S_IDLE;
				end
			end
			S_PUT: begin
				cmd     = CMD_PUT;
				state_d = S_IDLE;
			end
			S_PR_READ: begin
				cmd = CMD_PR_READ;
				if (stat.last) begin
					state_d = S_PR_DRAIN;
				end
			end
			S_PR_DRAIN: begin
				state_d = S_PR_FSET;
			end
			S_PR_FSET: begin
				cmd     = CMD_FSET;
				state_d = S_PR_FILL;
			end
			S_PR_FILL: begin
				if (stat.fill_done) begin
					cmd     = CMD_PR_END;
					state_d = S_IDLE;
				end else begin
					cmd = CMD_FILL;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- sv/wle_dp.sv -----
`include "waypoint_list_engine_macros.svh"

module wle_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  wle_pkg::item_t item,
	input  wle_pkg::cmd_t  cmd,
	output wle_pkg::stat_t stat,
	output logic           strobe,
	output wle_pkg::res_t  result
);
	import wle_pkg::*;

	typedef enum logic [2:0] {
		TAG_NONE,
		TAG_RESULT,
		TAG_MOVE,
		TAG_A,
		TAG_B,
		TAG_P
	} tag_t;

	point_t            mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;

	logic [3:0]        kind_q;
	logic [IDX_W-1:0]  idx_q;
	point_t            pt_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  kept_q;
	point_t            a_q, b_q, last_q;
	point_t            rdata_q;
	logic              rvalid_q;
	tag_t              rtag_s1;
	logic [ADDR_W-1:0] wdst_s1;
	res_t              res_q;
	logic              strobe_q;

	logic [CNT_W-1:0]  idx_ext, depth_c, cnt_m1, ptr_p1, ptr_m1, kept_m1;
	logic              full, reject, no_move, is_ins, coll;
	point_t            p;
	logic [ADDR_W-1:0] raddr, waddr;
	logic              we;
	point_t            wdata;
	logic [CNT_W-1:0]  count_d;
	logic              clear_d;
	res_t              res_d;
	logic              strobe_d;
	logic              tag_wr, cmd_wr_free;

	function automatic logic collinear(point_t a, point_t b, point_t c);
		return ((a.x == b.x) && (b.x == c.x)) || ((a.y == b.y) && (b.y == c.y));
	endfunction

	assign idx_ext = CNT_W'(idx_q);
	assign depth_c = CNT_W'(DEPTH);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign ptr_p1  = ptr_q + CNT_W'(1);
	assign ptr_m1  = ptr_q - CNT_W'(1);
	assign kept_m1 = kept_q - CNT_W'(1);
	assign full    = (count_q >= depth_c);
	assign is_ins  = (kind_q == OP_INSERT);
	// never-written entries read as zero
	assign p       = rvalid_q ? rdata_q : '0;
	assign coll    = collinear(a_q, b_q, p);

	assign tag_wr      = (rtag_s1 == TAG_MOVE) || (rtag_s1 == TAG_P);
	assign cmd_wr_free = (cmd == CMD_NONE) || (cmd == CMD_SHIFT) ||
		(cmd == CMD_PR_READ) || (cmd == CMD_REM_END);

	always_comb begin
		reject  = 1'b0;
		no_move = 1'b0;
		case (kind_q) inside
			OP_APPEND:               reject = full;
			OP_EDIT, OP_READ:        reject = (idx_ext >= depth_c);
			OP_INSERT: begin
				reject  = full || (idx_ext > count_q);
				no_move = (idx_ext == count_q);
			end
			OP_REMOVE: begin
				reject  = (idx_ext >= count_q);
				no_move = (idx_ext == cnt_m1);
			end
			OP_PRUNE:                no_move = (count_q < CNT_W'(3));
			OP_DROP, OP_CLEAR, OP_READ_LAST: reject = 1'b0;
			default:                 reject = 1'b1;
		endcase
	end

	always_comb begin
		stat.kind      = kind_q;
		stat.reject    = reject;
		stat.no_move   = no_move;
		stat.last      = is_ins ? (ptr_q == idx_ext) : (ptr_q == cnt_m1);
		stat.fill_done = (ptr_q >= count_q);
	end

	// read address
	always_comb begin
		case (cmd)
			CMD_RD: begin
				if (kind_q == OP_READ_LAST) begin
					raddr = (count_q == '0) ? '0 : cnt_m1[ADDR_W-1:0];
				end else begin
					raddr = idx_q[ADDR_W-1:0];
				end
			end
			CMD_SHIFT, CMD_PR_READ: raddr = ptr_q[ADDR_W-1:0];
			default:                raddr = '0;
		endcase
	end

	// single write port: read responses first, then direct writes
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = p;
		case (rtag_s1)
			TAG_MOVE: begin
				we    = 1'b1;
				waddr = wdst_s1;
			end
			TAG_P: begin
				we    = 1'b1;
				waddr = coll ? kept_m1[ADDR_W-1:0] : kept_q[ADDR_W-1:0];
			end
			default: begin
				case (cmd)
					CMD_SIMPLE: begin
						wdata = pt_q;
						if (!reject && kind_q == OP_APPEND) begin
							we    = 1'b1;
							waddr = count_q[ADDR_W-1:0];
						end else if (!reject && kind_q == OP_EDIT) begin
							we    = 1'b1;
							waddr = idx_q[ADDR_W-1:0];
						end
					end
					CMD_PUT: begin
						we    = 1'b1;
						waddr = idx_q[ADDR_W-1:0];
						wdata = pt_q;
					end
					CMD_FILL: begin
						we    = 1'b1;
						waddr = ptr_q[ADDR_W-1:0];
						wdata = last_q;
					end
					default: we = 1'b0;
				endcase
			end
		endcase
	end

	// count and result word
	always_comb begin
		count_d  = count_q;
		clear_d  = 1'b0;
		strobe_d = 1'b0;
		res_d    = '0;
		case (cmd)
			CMD_SIMPLE: begin
				if (!reject) begin
					case (kind_q) inside
						OP_APPEND: count_d = count_q + CNT_W'(1);
						OP_DROP:   count_d = (count_q == '0) ? count_q : cnt_m1;
						OP_CLEAR: begin
							count_d = '0;
							clear_d = 1'b1;
						end
						default:   count_d = count_q;
					endcase
				end
				strobe_d = 1'b1;
				res_d.status = reject;
			end
			CMD_PUT: begin
				count_d  = count_q + CNT_W'(1);
				strobe_d = 1'b1;
			end
			CMD_REM_END: begin
				count_d  = cnt_m1;
				strobe_d = 1'b1;
			end
			CMD_PR_END: begin
				count_d  = kept_q;
				strobe_d = 1'b1;
			end
			default: count_d = count_q;
		endcase
		if (rtag_s1 == TAG_RESULT) begin
			strobe_d  = 1'b1;
			res_d.out_x = p.x;
			res_d.out_y = p.y;
		end
		res_d.point_count = count_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
			count_q  <= '0;
			ptr_q    <= '0;
			kept_q   <= '0;
			rtag_s1  <= TAG_NONE;
			strobe_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[raddr];
			if (clear_d) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			count_q  <= count_d;
			strobe_q <= strobe_d;
			case (cmd)
				CMD_RD: rtag_s1 <= TAG_RESULT;
				CMD_BEGIN: begin
					rtag_s1 <= TAG_NONE;
					kept_q  <= CNT_W'(2);
					case (kind_q) inside
						OP_INSERT: ptr_q <= cnt_m1;
						OP_REMOVE: ptr_q <= idx_ext + CNT_W'(1);
						default:   ptr_q <= '0;
					endcase
				end
				CMD_SHIFT: begin
					rtag_s1 <= TAG_MOVE;
					ptr_q   <= is_ins ? ptr_m1 : ptr_p1;
				end
				CMD_PR_READ: begin
					if (ptr_q == CNT_W'(0)) begin
						rtag_s1 <= TAG_A;
					end else if (ptr_q == CNT_W'(1)) begin
						rtag_s1 <= TAG_B;
					end else begin
						rtag_s1 <= TAG_P;
					end
					ptr_q <= ptr_p1;
				end
				CMD_FSET: begin
					rtag_s1 <= TAG_NONE;
					ptr_q   <= kept_q;
				end
				CMD_FILL: begin
					rtag_s1 <= TAG_NONE;
					ptr_q   <= ptr_p1;
				end
				default: begin
					rtag_s1 <= TAG_NONE;
					ptr_q   <= ptr_q;
				end
			endcase
			if (rtag_s1 == TAG_P && !coll) begin
				kept_q <= kept_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_CAPTURE) begin
			kind_q <= item.kind;
			idx_q  <= item.index;
			pt_q   <= {item.coord_y, item.coord_x};
		end
		if (cmd == CMD_SHIFT) begin
			wdst_s1 <= is_ins ? ptr_p1[ADDR_W-1:0] : ptr_m1[ADDR_W-1:0];
		end
		case (rtag_s1)
			TAG_A: a_q <= p;
			TAG_B: b_q <= p;
			TAG_P: begin
				// the kept pair tracks store[kept-2] and store[kept-1]
				if (!coll) begin
					a_q <= b_q;
				end
				b_q    <= p;
				last_q <= p;
			end
			default: b_q <= b_q;
		endcase
		if (strobe_d) begin
			res_q <= res_d;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

	`WLE_ASSERT_IMP(a_wr_port_free, clk, arst_n, tag_wr, cmd_wr_free)
	`WLE_ASSERT_IMP(a_kept_below_count, clk, arst_n, rtag_s1 == TAG_P, kept_q < count_q)
	`WLE_ASSERT_NEXT(a_put_grows_count, clk, arst_n, cmd == CMD_PUT, count_q == $past(count_q) + CNT_W'(1))

endmodule

// ----- sv/waypoint_list_engine.sv -----
// channel  dir  ports                handshake
// command  in   start, item, busy    word taken at a clock edge with start high, busy low
// result   out  strobe, result       one word per command, valid for one cycle, no stall
//
// results are registered; a read also passes the registered store read first
// insert and remove move one entry per cycle through the store's single read and write port
// prune reads each entry once, then refills the tail one entry a cycle
// reset clears the count and all per-entry valid bits at once; no clearing pass is run
// the receiver cannot stall: a result word is lost if not taken in its strobe cycle
module waypoint_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  wle_pkg::item_t item,
	output logic           busy,
	output logic           strobe,
	output wle_pkg::res_t  result
);
	import wle_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	wle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	wle_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule
